>>> sv/escape_char_decoder_core_defines.svh
// Assertion macros shared by the escape character decoder checker.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef ESCAPE_CHAR_DECODER_CORE_DEFINES_SVH
`define ESCAPE_CHAR_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ECD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ECD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define ECD_ASSERT_NXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ecd_pkg.sv
// Types, codes and helper functions of the escape character decoder.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ecd_pkg;

  // Token parse phase.
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ESC   = 3'd1,
    PH_HOLD  = 3'd2,
    PH_HEX   = 3'd3,
    PH_OCT   = 3'd4,
    PH_OTHER = 3'd5,
    PH_ERR   = 3'd6
  } phase_t;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_BAD_VALUE = 3'd2;
  localparam logic [2:0] ST_IMPROPER  = 3'd3;
  localparam logic [2:0] ST_EMPTY_ESC = 3'd4;
  localparam logic [2:0] ST_EXTRA     = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [7:0] MAX_CODE_RESET = 8'hFF;
  localparam logic [4:0] HEX_INVALID    = 5'd16;

  // One request of the input channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty_req;
  } item_t;

  // Token state carried from one character to the next.
  typedef struct packed {
    phase_t     phase;
    logic [7:0] accum;
    logic [2:0] err_code;
    logic [7:0] held_char;
    logic [1:0] nonspace_count;
  } tok_state_t;

  localparam tok_state_t TOK_STATE_RESET = '{
    phase:          PH_START,
    accum:          8'd0,
    err_code:       ST_OK,
    held_char:      CH_SPACE,
    nonspace_count: 2'd0
  };

  // One result of the step logic.
  typedef struct packed {
    logic       vld;
    logic [7:0] value;
    logic [2:0] status;
  } result_t;

  // Simple escapes; bit 8 set means the character is one.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    begin
      case (c)
        8'h61:   r = {1'b1, 8'd7};   // a
        8'h62:   r = {1'b1, 8'd8};   // b
        8'h66:   r = {1'b1, 8'd12};  // f
        8'h6E:   r = {1'b1, 8'd10};  // n
        8'h72:   r = {1'b1, 8'd13};  // r
        8'h74:   r = {1'b1, 8'd9};   // t
        8'h76:   r = {1'b1, 8'd11};  // v
        8'h5C:   r = {1'b1, 8'd92};  // backslash
        8'h22:   r = {1'b1, 8'd34};  // double quote
        8'h27:   r = {1'b1, 8'd39};  // single quote
        8'h3F:   r = {1'b1, 8'd63};  // question mark
        8'h24:   r = {1'b1, 8'd36};  // dollar
        default: r = 9'd0;
      endcase
      return r;
    end
  endfunction

  // Hex digit value, or HEX_INVALID for anything that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
      end else begin
        d = {3'd0, HEX_INVALID};
      end
      return d[4:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/ecd_in_stage.sv
// Input register of the escape character decoder: holds one request.
// Depends on ecd_pkg.
`default_nettype none

module ecd_in_stage
  import ecd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t item_i,
  input  wire logic  take,
  output logic       vld_o,
  output item_t      item_o
);

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  // Room when empty or when the held request leaves this cycle.
  assign in_ready = !vld_r || take;
  assign vld_nxt  = (in_valid && in_ready) || (vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_i;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

`default_nettype wire

>>> sv/ecd_step.sv
// Per-character step of the escape character decoder: next token state
// and the result at token end. Depends on ecd_pkg.
`default_nettype none

module ecd_step
  import ecd_pkg::*;
(
  input  wire tok_state_t st_i,
  input  wire item_t      item_i,
  input  wire logic [7:0] max_code,
  output tok_state_t      st_o,
  output result_t         res_o
);

  always_comb begin
    tok_state_t  nxt;
    result_t     res;
    logic [8:0]  esc;
    logic [7:0]  dig;
    logic        is_digit;
    logic [4:0]  hexv;
    logic [11:0] hex_acc;
    logic [11:0] oct_acc;
    logic [11:0] max_ext;
    logic [7:0]  c;

    c        = item_i.ch;
    nxt      = st_i;
    res      = '0;
    esc      = simple_escape(c);
    dig      = c - CH_ZERO;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    hexv     = hex_value(c);
    hex_acc  = {st_i.accum, 4'h0} + {8'd0, hexv[3:0]};
    oct_acc  = {1'b0, st_i.accum, 3'd0} + {9'd0, dig[2:0]};
    max_ext  = {4'd0, max_code};

    // Advance the token state by one character.
    if (!item_i.empty_req) begin
      case (st_i.phase)
        PH_START: begin
          if (c == CH_BSLASH) begin
            nxt.phase = PH_ESC;
          end else if (item_i.last) begin
            nxt.held_char = c;
            nxt.phase     = PH_HOLD;
          end else begin
            nxt.phase    = PH_ERR;
            nxt.err_code = ST_EXTRA;
          end
        end
        PH_ESC: begin
          if (esc[8]) begin
            nxt.held_char = esc[7:0];
            nxt.phase     = PH_HOLD;
          end else if (c == CH_X) begin
            if (item_i.last) begin
              nxt.phase    = PH_ERR;
              nxt.err_code = ST_EMPTY_ESC;
            end else begin
              nxt.accum = 8'd0;
              nxt.phase = PH_HEX;
            end
          end else if (is_digit) begin
            if (dig[3] || dig > max_code) begin
              nxt.phase    = PH_ERR;
              nxt.err_code = ST_BAD_VALUE;
            end else begin
              nxt.accum = dig;
              nxt.phase = PH_OCT;
            end
          end else begin
            nxt.held_char      = c;
            nxt.nonspace_count = (c != CH_SPACE) ? 2'd1 : 2'd0;
            nxt.phase          = PH_OTHER;
          end
        end
        PH_HEX: begin
          if (hexv[4] || hex_acc > max_ext) begin
            nxt.phase    = PH_ERR;
            nxt.err_code = ST_BAD_VALUE;
          end else begin
            nxt.accum = hex_acc[7:0];
          end
        end
        PH_OCT: begin
          if (!is_digit) begin
            nxt.phase    = PH_ERR;
            nxt.err_code = ST_IMPROPER;
          end else if (dig[3] || oct_acc > max_ext) begin
            nxt.phase    = PH_ERR;
            nxt.err_code = ST_BAD_VALUE;
          end else begin
            nxt.accum = oct_acc[7:0];
          end
        end
        PH_OTHER: begin
          if (c != CH_SPACE) begin
            if (st_i.nonspace_count == 2'd0) begin
              nxt.held_char = c;
            end
            if (st_i.nonspace_count != 2'd2) begin
              nxt.nonspace_count = st_i.nonspace_count + 2'd1;
            end
          end
        end
        default: begin
          // Held character and decided errors ignore further characters.
        end
      endcase
    end

    // Report at token end and start a fresh token.
    if (item_i.empty_req || item_i.last) begin
      res.vld    = 1'b1;
      res.status = ST_OK;
      res.value  = CH_SPACE;
      if (item_i.empty_req) begin
        res.status = ST_EMPTY;
      end else begin
        case (nxt.phase)
          PH_HOLD:  res.value = nxt.held_char;
          PH_HEX:   res.value = nxt.accum;
          PH_OCT:   res.value = nxt.accum;
          PH_OTHER: begin
            if (nxt.nonspace_count == 2'd1) begin
              res.value = nxt.held_char;
            end else begin
              res.status = ST_IMPROPER;
            end
          end
          PH_ESC:   res.status = ST_EMPTY_ESC;
          PH_ERR:   res.status = nxt.err_code;
          default:  res.status = ST_EMPTY;
        endcase
      end
      if (res.status != ST_OK) begin
        res.value = CH_SPACE;
      end
      nxt = TOK_STATE_RESET;
    end

    st_o  = nxt;
    res_o = res;
  end

endmodule

`default_nettype wire

>>> sv/ecd_out_stage.sv
// Result register of the escape character decoder.
// Depends on ecd_pkg.
`default_nettype none

module ecd_out_stage
  import ecd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res_i,
  output logic         can_take,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic [7:0]   out_value,
  output logic [2:0]   out_status
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] value_r;
  logic [2:0] status_r;
  logic       load_res;

  // The register can be refilled when empty or drained this cycle.
  assign can_take = !vld_r || out_ready;
  assign load_res = load && res_i.vld;
  assign vld_nxt  = load_res || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      value_r  <= res_i.value;
      status_r <= res_i.status;
    end
  end

  assign out_valid  = vld_r;
  assign out_value  = value_r;
  assign out_status = status_r;

endmodule

`default_nettype wire

>>> sv/escape_char_decoder_core.sv
// Escape character decoder: takes the characters of a token one request per
// cycle unless the result register is full and stalled, and returns one
// character code with a status when the token ends. The token state is
// updated between the input register and the result register; the request
// that ends a token is registered in the input register, its result then in
// the result register, and it waits only while the result channel stalls.
// max_code is written through cfg_wr_en/cfg_wr_data and resets to 255.
// Depends on ecd_pkg, ecd_in_stage, ecd_step and ecd_out_stage.
`default_nettype none

module escape_char_decoder_core
  import ecd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_last,
  input  wire logic       in_empty_req,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_value,
  output logic [2:0]      out_status,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  item_t      in_item;
  item_t      held_item;
  logic       held_vld;
  logic       can_take;
  logic       fire;
  tok_state_t tok_r;
  tok_state_t tok_nxt;
  result_t    res;
  logic [7:0] max_code_r;

  assign in_item = '{ch: in_ch, last: in_last, empty_req: in_empty_req};

  // Input register.
  ecd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_i   (in_item),
    .take     (fire),
    .vld_o    (held_vld),
    .item_o   (held_item)
  );

  // A held request is processed when the result register has room.
  assign fire = held_vld && can_take;

  ecd_step u_step (
    .st_i     (tok_r),
    .item_i   (held_item),
    .max_code (max_code_r),
    .st_o     (tok_nxt),
    .res_o    (res)
  );

  // Token state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r      <= TOK_STATE_RESET;
      max_code_r <= MAX_CODE_RESET;
    end else begin
      if (fire) begin
        tok_r <= tok_nxt;
      end
      if (cfg_wr_en) begin
        max_code_r <= cfg_wr_data;
      end
    end
  end

  // Result register.
  ecd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res_i      (res),
    .can_take   (can_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

`default_nettype wire

>>> sv/ecd_checker.sv
// Port-level checks of the escape character decoder, bound to the top level.
// Depends on ecd_pkg and escape_char_decoder_core_defines.svh.
`default_nettype none
`include "escape_char_decoder_core_defines.svh"

module ecd_checker
  import ecd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_value,
  input wire logic [2:0] out_status
);

  // A stalled result keeps its contents.
  `ECD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_status), "stalled result changed")

  // Any failure status carries the space code.
  `ECD_ASSERT_IMP(a_err_space, out_valid && (out_status != ST_OK), out_value == CH_SPACE, "error result not space")

  // Only defined status codes appear.
  `ECD_ASSERT_IMP(a_status_range, out_valid, out_status <= ST_EXTRA, "undefined status code")

  // The input side stalls only behind a stalled result.
  `ECD_ASSERT_IMP(a_backpressure, !in_ready, out_valid && !out_ready, "input stalled without output stall")

  // Reset empties the result register.
  `ECD_ASSERT_NXT_ALWAYS(a_reset_clear, !rst_n, !out_valid, "result valid after reset")

endmodule

bind escape_char_decoder_core ecd_checker u_ecd_checker (.*);

`default_nettype wire

>>> bench/escape_decode_checker.sv
// Checker for the escape character decoder: watches the request, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on ecd_pkg for the phase type, the status codes and character codes.
`timescale 1ns / 1ps

module escape_decode_checker
  import ecd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  input  logic       in_empty_req,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_value,
  input  logic [2:0] out_status,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output int         mismatch_count,
  output int         results_due
);

  localparam int unsigned HEX_RADIX  = 16;
  localparam int unsigned OCT_RADIX  = 8;
  localparam int unsigned NOT_SIMPLE = 256;

  // One decoded character as the result channel should carry it.
  typedef struct packed {
    logic [7:0] value;
    logic [2:0] status;
  } decoded_t;

  decoded_t    due_codes[$];
  phase_t      tok_phase;
  logic [11:0] tok_accum;
  logic [2:0]  tok_err;
  logic [7:0]  tok_held;
  logic [1:0]  tok_nonspace;
  logic [7:0]  code_limit;

  // Code of a one-character escape, or NOT_SIMPLE when c is not one.
  function automatic int unsigned simple_escape_code(input logic [7:0] c);
    case (c)
      "a":     return 7;
      "b":     return 8;
      "f":     return 12;
      "n":     return 10;
      "r":     return 13;
      "t":     return 9;
      "v":     return 11;
      "\\":    return 92;
      "\"":    return 34;
      "'":     return 39;
      "?":     return 63;
      "$":     return 36;
      default: return NOT_SIMPLE;
    endcase
  endfunction

  // Hex digit value; any character that is not a hex digit maps to HEX_RADIX.
  function automatic int unsigned hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return HEX_RADIX;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_token();
    tok_phase    = PH_START;
    tok_accum    = '0;
    tok_err      = ST_OK;
    tok_held     = CH_SPACE;
    tok_nonspace = 2'd0;
  endtask

  task automatic mark_error(input logic [2:0] code);
    tok_phase = PH_ERR;
    tok_err   = code;
  endtask

  // Moves the token state on by one character.
  task automatic advance_token(input logic [7:0] c, input logic is_last);
    int unsigned v;
    case (tok_phase)
      PH_START: begin
        if (c == CH_BSLASH) begin
          tok_phase = PH_ESC;
        end else if (is_last) begin
          tok_held  = c;
          tok_phase = PH_HOLD;
        end else begin
          mark_error(ST_EXTRA);
        end
      end
      PH_ESC: begin
        v = simple_escape_code(c);
        if (v < NOT_SIMPLE) begin
          tok_held  = v[7:0];
          tok_phase = PH_HOLD;
        end else if (c == CH_X) begin
          if (is_last) begin
            mark_error(ST_EMPTY_ESC);
          end else begin
            tok_accum = '0;
            tok_phase = PH_HEX;
          end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          v = c - CH_ZERO;
          if (v >= OCT_RADIX || v > code_limit) begin
            mark_error(ST_BAD_VALUE);
          end else begin
            tok_accum = v[11:0];
            tok_phase = PH_OCT;
          end
        end else begin
          // Any other escape: exactly one non-space character must follow.
          tok_held     = c;
          tok_nonspace = (c != CH_SPACE) ? 2'd1 : 2'd0;
          tok_phase    = PH_OTHER;
        end
      end
      PH_HEX: begin
        v = hex_digit(c);
        if (v >= HEX_RADIX) begin
          mark_error(ST_BAD_VALUE);
        end else begin
          v = int'(tok_accum) * HEX_RADIX + v;
          if (v > code_limit) mark_error(ST_BAD_VALUE);
          else tok_accum = v[11:0];
        end
      end
      PH_OCT: begin
        if (c < CH_ZERO || c > CH_NINE) begin
          mark_error(ST_IMPROPER);
        end else begin
          v = c - CH_ZERO;
          if (v >= OCT_RADIX) begin
            mark_error(ST_BAD_VALUE);
          end else begin
            v = int'(tok_accum) * OCT_RADIX + v;
            if (v > code_limit) mark_error(ST_BAD_VALUE);
            else tok_accum = v[11:0];
          end
        end
      end
      PH_OTHER: begin
        if (c != CH_SPACE) begin
          if (tok_nonspace == 2'd0) tok_held = c;
          if (tok_nonspace < 2'd2) tok_nonspace++;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Applies one accepted request and queues the result it ends the token with.
  task automatic decode_request(input logic [7:0] c, input logic is_last,
                                input logic is_empty);
    decoded_t d;
    d.value  = CH_SPACE;
    d.status = ST_OK;
    if (is_empty) begin
      d.status = ST_EMPTY;
    end else begin
      advance_token(c, is_last);
      if (!is_last) return;
      case (tok_phase)
        PH_HOLD:        d.value = tok_held;
        PH_HEX, PH_OCT: d.value = tok_accum[7:0];
        PH_OTHER: begin
          if (tok_nonspace == 2'd1) d.value = tok_held;
          else d.status = ST_IMPROPER;
        end
        PH_ESC:  d.status = ST_EMPTY_ESC;
        PH_ERR:  d.status = tok_err;
        default: d.status = ST_EMPTY;
      endcase
    end
    if (d.status != ST_OK) d.value = CH_SPACE;
    due_codes.push_back(d);
    clear_token();
  endtask

  // Compares an accepted result with the oldest one still due.
  task automatic check_result();
    decoded_t want;
    if (due_codes.size() == 0) begin
      report_mismatch($sformatf("result with none due: value=%0d status=%0d",
                                out_value, out_status));
    end else begin
      want = due_codes.pop_front();
      if (out_value !== want.value)
        report_mismatch($sformatf("value %0d, expected %0d (status %0d)",
                                  out_value, want.value, want.status));
      if (out_status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d",
                                  out_status, want.status));
    end
  endtask

  // All ports are sampled at the rising edge, before the bench and the block
  // update them.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_token();
      code_limit = MAX_CODE_RESET;
      mismatch_count = 0;
      due_codes.delete();
    end else begin
      if (cfg_wr_en) code_limit = cfg_wr_data;
      if (in_valid && in_ready) decode_request(in_ch, in_last, in_empty_req);
      if (out_valid && out_ready) check_result();
    end
    results_due <= due_codes.size();
  end

endmodule

>>> bench/tb_escape_char_decoder_core.sv
// Testbench top for escape_char_decoder_core: drives tokens as requests with
// random gaps and stalls, rewrites max_code between phases, gives the verdict.
// Depends on ecd_pkg, the block and escape_decode_checker.
`timescale 1ns / 1ps

module tb_escape_char_decoder_core;
  import ecd_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASES       = 6;
  localparam int MAX_GAP      = 11;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [7:0] LIMIT_TABLE [0:PHASES-1] =
    '{8'd255, 8'd7, 8'd0, 8'd63, 8'd100, 8'd200};

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_ch;
  logic       in_last;
  logic       in_empty_req;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_value;
  logic [2:0] out_status;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  int         mismatch_count;
  int         results_due;
  int         items_sent = 0;
  int         cycle_count = 0;
  bit         send_burst = 1'b0;
  bit         recv_burst = 1'b0;
  bit         hold_off_req = 1'b0;
  logic [7:0] token_q[$];

  escape_char_decoder_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .in_last      (in_last),
    .in_empty_req (in_empty_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_status   (out_status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  escape_decode_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .in_empty_req   (in_empty_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_status     (out_status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one request after a random gap and waits until it is taken.
  task automatic send_request(input logic [7:0] c, input logic is_last,
                              input logic is_empty);
    int gap;
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_ch        <= c;
    in_last      <= is_last;
    in_empty_req <= is_empty;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  // Sends token_q with last on its final character. A cut token is sent
  // without last and then dropped by an empty request, as is a token with
  // no characters at all.
  task automatic send_token(input bit cut);
    int n;
    n = token_q.size();
    for (int i = 0; i < n; i++)
      send_request(token_q[i], !cut && (i == n - 1), 1'b0);
    if (cut || n == 0)
      send_request(random_byte(), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic send_text(input string s, input bit cut);
    token_q.delete();
    foreach (s[i]) token_q.push_back(s[i]);
    send_token(cut);
  endtask

  // Idles the input and waits until every result is in and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_code(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed tokens with random content, plus noise and cut tokens.
  task automatic build_random_token(output bit cut);
    string simple_set;
    string hex_set;
    int    kind;
    int    n;
    int    r;
    simple_set = "abfnrtv\\\"'?$";
    hex_set    = "0123456789abcdefABCDEF";
    token_q.delete();
    kind = $urandom_range(0, 99);
    cut  = ($urandom_range(0, 19) == 0);
    if (kind < 10) begin
      token_q.push_back(random_byte());
    end else if (kind < 25) begin
      // Simple escape; trailing characters should be ignored.
      token_q.push_back(CH_BSLASH);
      token_q.push_back(simple_set[$urandom_range(0, simple_set.len() - 1)]);
      n = $urandom_range(0, 2);
      repeat (n) token_q.push_back(random_byte());
    end else if (kind < 45) begin
      // Hex escape, now and then with a stray character among the digits.
      token_q.push_back(CH_BSLASH);
      token_q.push_back(CH_X);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0) token_q.push_back(random_byte());
        else if (i == 0 && r < 4) token_q.push_back(CH_ZERO);
        else token_q.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
      end
    end else if (kind < 65) begin
      // Octal escape, with occasional digits 8 or 9 and non-digits.
      token_q.push_back(CH_BSLASH);
      if ($urandom_range(0, 9) == 0)
        token_q.push_back(8'(CH_ZERO + $urandom_range(8, 9)));
      else
        token_q.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 19);
        if (r == 0) token_q.push_back(random_byte());
        else if (r == 1) token_q.push_back(8'(CH_ZERO + $urandom_range(8, 9)));
        else token_q.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
      end
    end else if (kind < 80) begin
      // Other escape followed mostly by spaces.
      token_q.push_back(CH_BSLASH);
      token_q.push_back(random_byte());
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++)
        token_q.push_back(($urandom_range(0, 9) < 6) ? CH_SPACE : random_byte());
    end else if (kind < 88) begin
      n = $urandom_range(1, 4);
      repeat (n) token_q.push_back(random_byte());
      if ($urandom_range(0, 2) == 0) token_q[0] = CH_BSLASH;
    end else if (kind < 94) begin
      // Escape that ends before it has a body.
      token_q.push_back(CH_BSLASH);
      if ($urandom_range(0, 1) == 1) token_q.push_back(CH_X);
    end
  endtask

  // Result side: random stalls, bursts without stalls, and the long hold-off.
  initial begin : result_sink
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stimulus
    bit cut;
    int phase_end;
    in_valid     <= 1'b0;
    in_ch        <= '0;
    in_last      <= 1'b0;
    in_empty_req <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    rst_n        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed tokens with max_code at its reset value.
    send_text("A", 1'b0);
    send_text("", 1'b0);
    send_text("\\$z", 1'b0);
    send_text("\\x", 1'b0);
    send_text("\\", 1'b0);
    send_text("\\xFf", 1'b0);
    send_text("\\9", 1'b0);
    send_text("\\q", 1'b0);
    send_text("ab", 1'b0);
    send_text("\\", 1'b1);

    // A single octal digit above the limit is refused.
    settle();
    write_max_code(8'd0);
    send_text("\\1", 1'b0);

    // Random phases, each under its own max_code.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_max_code(LIMIT_TABLE[p]);
      if (p == 1 || p == 4) hold_off_req = 1'b1;
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) begin
        build_random_token(cut);
        send_token(cut);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
